/* rtl/core/mp3_module_command_framer_macros.svh */
// Assertion macros shared by the framer RTL.
`ifndef MP3_MODULE_COMMAND_FRAMER_MACROS_SVH
`define MP3_MODULE_COMMAND_FRAMER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MCF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("framer check failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define MCF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("framer check failed: next-cycle implication");

`endif

/* rtl/core/mcf_pkg.sv */
// Package: widths, command codes, frame bytes and lengths for the MP3 command framer.
`default_nettype none

package mcf_pkg;

    localparam int unsigned CMD_W      = 8;
    localparam int unsigned ARG_W      = 16;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned VOL_W      = 5;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 5;
    localparam int unsigned CNT_W      = 5;

    typedef logic [CFG_IDX_W-1:0] cfg_index_t;
    localparam cfg_index_t REG_PROTOCOL_MODE  = 1'b0;
    localparam cfg_index_t REG_DEFAULT_VOLUME = 1'b1;

    typedef enum logic {
        PROTO_LONG  = 1'b0,
        PROTO_SHORT = 1'b1
    } proto_t;

    localparam logic [VOL_W-1:0] VOLUME_RESET = 5'd30;

    // command codes
    localparam logic [CMD_W-1:0] CMD_TRACK    = 8'h03;
    localparam logic [CMD_W-1:0] CMD_PLAYBACK = 8'h0D;
    localparam logic [CMD_W-1:0] CMD_STOP     = 8'h16;
    localparam logic [CMD_W-1:0] CMD_VOLUME   = 8'h06;
    localparam logic [CMD_W-1:0] CMD_RESET    = 8'h0C;

    // ten-byte frame
    localparam logic [BYTE_W-1:0] LONG_START = 8'h7E;
    localparam logic [BYTE_W-1:0] LONG_VER   = 8'hFF;
    localparam logic [BYTE_W-1:0] LONG_LEN   = 8'h06;
    localparam logic [BYTE_W-1:0] LONG_PAD   = 8'h00;
    localparam logic [BYTE_W-1:0] LONG_END   = 8'hEF;

    // AA frames
    localparam logic [BYTE_W-1:0] SHORT_START     = 8'hAA;
    localparam logic [BYTE_W-1:0] SHORT_TRACK_OP  = 8'h07;
    localparam logic [BYTE_W-1:0] SHORT_TRACK_LEN = 8'h02;
    localparam logic [BYTE_W-1:0] SHORT_PLAY_OP   = 8'h02;
    localparam logic [BYTE_W-1:0] SHORT_PLAY_LEN  = 8'h00;
    localparam logic [BYTE_W-1:0] SHORT_PLAY_DATA = 8'hAC;
    localparam logic [BYTE_W-1:0] SHORT_STOP_OP   = 8'h10;
    localparam logic [BYTE_W-1:0] SHORT_STOP_LEN  = 8'h00;
    localparam logic [BYTE_W-1:0] SHORT_STOP_DATA = 8'hBA;
    localparam logic [BYTE_W-1:0] SHORT_VOL_OP    = 8'h13;
    localparam logic [BYTE_W-1:0] SHORT_VOL_LEN   = 8'h01;

    // bytes per request
    localparam logic [CNT_W-1:0] LEN_NONE      = 5'd0;
    localparam logic [CNT_W-1:0] LEN_SHORT     = 5'd5;
    localparam logic [CNT_W-1:0] LEN_LONG      = 5'd10;
    localparam logic [CNT_W-1:0] LEN_TRACK     = 5'd11;
    localparam logic [CNT_W-1:0] LEN_LONG_PAIR = 5'd20;
    localparam logic [CNT_W-1:0] TRACK_FRAME   = 5'd6;

endpackage

`default_nettype wire

/* rtl/core/mcf_if.sv */
// Interfaces: command request channel and serial byte channel.
`default_nettype none

interface mcf_cmd_if;
    logic                            valid;
    logic                            ready;
    logic [mcf_pkg::CMD_W-1:0]       command_byte;
    logic [mcf_pkg::ARG_W-1:0]       argument;

    modport source (output valid, output command_byte, output argument, input ready);
    modport sink   (input valid, input command_byte, input argument, output ready);
endinterface

interface mcf_byte_if;
    logic                            valid;
    logic                            ready;
    logic [mcf_pkg::BYTE_W-1:0]      out_byte;
    logic                            frame_end;
    logic                            last;

    modport source (output valid, output out_byte, output frame_end, output last, input ready);
    modport sink   (input valid, input out_byte, input frame_end, input last, output ready);
endinterface

`default_nettype wire

/* rtl/core/mp3_module_command_framer.sv */
// Top level: frames player command requests into serial bytes, two protocols.
//
//  channel       dir  payload                           use
//  command       in   command_byte[7:0], argument[15:0] one player command request
//  serial_bytes  out  out_byte[7:0], frame_end, last    one serial byte per transfer
//  write_*       in   write_index[0], write_data[4:0]   protocol_mode, default_volume
//
// One byte leaves per cycle unless serial_bytes stalls: a request has as many bytes
// as its frames (5, 10, 11 or 20), stepped through by the byte counter.
// The next request is taken in the cycle its predecessor's last byte loads the
// output register; a request with no bytes is taken and dropped, and the framer stays idle.
// A stall on serial_bytes holds the output register and the byte counter.
// Reset clears the counter and valids; registers return to 0 and 30.
`default_nettype none
`include "mp3_module_command_framer_macros.svh"

module mp3_module_command_framer (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    mcf_cmd_if.sink                                command,
    mcf_byte_if.source                             serial_bytes,
    input  wire logic                              write_en,
    input  wire logic [mcf_pkg::CFG_IDX_W-1:0]     write_index,
    input  wire logic [mcf_pkg::CFG_DATA_W-1:0]    write_data
);

    mcf_pkg::proto_t                    mode_reg;
    logic [mcf_pkg::VOL_W-1:0]          volume_reg;

    logic                               busy_reg;
    logic                               busy_next;
    logic [mcf_pkg::CNT_W-1:0]          idx_reg;
    logic [mcf_pkg::CNT_W-1:0]          idx_next;
    logic [mcf_pkg::CNT_W-1:0]          len_reg;
    logic [mcf_pkg::CNT_W-1:0]          len_in;
    logic [mcf_pkg::CMD_W-1:0]          cmd_reg;
    logic [mcf_pkg::ARG_W-1:0]          arg_reg;

    logic                               out_valid_reg;
    logic [mcf_pkg::BYTE_W-1:0]         out_byte_reg;
    logic                               frame_end_reg;
    logic                               last_reg;

    logic                               load;
    logic                               emit;
    logic                               final_byte;
    logic                               accept;

    // byte generation
    logic                               second_frame;
    logic [mcf_pkg::CNT_W-1:0]          long_pos_w;
    logic [3:0]                         long_pos;
    logic [mcf_pkg::CMD_W-1:0]          frame_cmd;
    logic [mcf_pkg::ARG_W-1:0]          frame_arg;
    logic [mcf_pkg::ARG_W-1:0]          long_sum;
    logic [mcf_pkg::ARG_W-1:0]          long_chk;
    logic                               is_track;
    logic                               track_part;
    logic [mcf_pkg::CNT_W-1:0]          short_pos_w;
    logic [2:0]                         short_pos;
    logic [mcf_pkg::BYTE_W-1:0]         sb1;
    logic [mcf_pkg::BYTE_W-1:0]         sb2;
    logic [mcf_pkg::BYTE_W-1:0]         sb3;
    logic [mcf_pkg::BYTE_W-1:0]         short_sum;
    logic [mcf_pkg::BYTE_W-1:0]         track_sum;
    logic [mcf_pkg::BYTE_W-1:0]         byte_next;
    logic                               frame_end_next;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= mcf_pkg::PROTO_LONG;
            volume_reg <= mcf_pkg::VOLUME_RESET;
        end
        else if (write_en)
        begin
            case (write_index)
                mcf_pkg::REG_PROTOCOL_MODE:
                    mode_reg <= mcf_pkg::proto_t'(write_data[0]);
                mcf_pkg::REG_DEFAULT_VOLUME:
                    volume_reg <= write_data[mcf_pkg::VOL_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // handshake
    assign load       = !out_valid_reg || serial_bytes.ready;
    assign emit       = busy_reg && load;
    assign final_byte = (idx_reg == len_reg - 5'd1);
    assign command.ready = !busy_reg || (emit && final_byte);
    assign accept     = command.valid && command.ready;

    always_comb
    begin
        case (mode_reg)
            mcf_pkg::PROTO_LONG:
                len_in = (command.command_byte == mcf_pkg::CMD_RESET)
                         ? mcf_pkg::LEN_LONG_PAIR : mcf_pkg::LEN_LONG;
            mcf_pkg::PROTO_SHORT:
                case (command.command_byte)
                    mcf_pkg::CMD_TRACK:    len_in = mcf_pkg::LEN_TRACK;
                    mcf_pkg::CMD_PLAYBACK: len_in = mcf_pkg::LEN_SHORT;
                    mcf_pkg::CMD_STOP:     len_in = mcf_pkg::LEN_SHORT;
                    mcf_pkg::CMD_VOLUME:   len_in = mcf_pkg::LEN_SHORT;
                    default:               len_in = mcf_pkg::LEN_NONE;
                endcase
            default:
                len_in = mcf_pkg::LEN_NONE;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (emit)
        begin
            idx_next = idx_reg + 5'd1;
            if (final_byte)
                busy_next = 1'b0;
        end
        if (accept)
        begin
            idx_next  = '0;
            busy_next = (len_in != mcf_pkg::LEN_NONE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            if (load)
                out_valid_reg <= busy_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= command.command_byte;
            arg_reg <= command.argument;
            len_reg <= len_in;
        end
        if (emit)
        begin
            out_byte_reg  <= byte_next;
            frame_end_reg <= frame_end_next;
            last_reg      <= final_byte;
        end
    end

    // ten-byte frames; the second one is the volume follow-up after a reset
    assign second_frame = (idx_reg >= mcf_pkg::LEN_LONG);
    assign long_pos_w   = second_frame ? idx_reg - mcf_pkg::LEN_LONG : idx_reg;
    assign long_pos     = long_pos_w[3:0];
    assign frame_cmd    = second_frame ? mcf_pkg::CMD_VOLUME : cmd_reg;
    assign frame_arg    = second_frame
                          ? {{(mcf_pkg::ARG_W-mcf_pkg::VOL_W){1'b0}}, volume_reg} : arg_reg;
    assign long_sum     = 16'(mcf_pkg::LONG_VER) + 16'(mcf_pkg::LONG_LEN) + 16'(frame_cmd)
                          + 16'(frame_arg[15:8]) + 16'(frame_arg[7:0]);
    assign long_chk     = ~long_sum + 16'd1;

    // AA frames; track is followed by a play frame
    assign is_track    = (cmd_reg == mcf_pkg::CMD_TRACK);
    assign track_part  = is_track && (idx_reg < mcf_pkg::TRACK_FRAME);
    assign short_pos_w = is_track ? idx_reg - mcf_pkg::TRACK_FRAME : idx_reg;
    assign short_pos   = short_pos_w[2:0];

    always_comb
    begin
        case (cmd_reg)
            mcf_pkg::CMD_STOP:
            begin
                sb1 = mcf_pkg::SHORT_STOP_OP;
                sb2 = mcf_pkg::SHORT_STOP_LEN;
                sb3 = mcf_pkg::SHORT_STOP_DATA;
            end
            mcf_pkg::CMD_VOLUME:
            begin
                sb1 = mcf_pkg::SHORT_VOL_OP;
                sb2 = mcf_pkg::SHORT_VOL_LEN;
                sb3 = arg_reg[7:0];
            end
            default:
            begin
                sb1 = mcf_pkg::SHORT_PLAY_OP;
                sb2 = mcf_pkg::SHORT_PLAY_LEN;
                sb3 = mcf_pkg::SHORT_PLAY_DATA;
            end
        endcase
    end

    assign short_sum = mcf_pkg::SHORT_START + sb1 + sb2 + sb3;
    assign track_sum = mcf_pkg::SHORT_START + mcf_pkg::SHORT_TRACK_OP
                       + mcf_pkg::SHORT_TRACK_LEN + arg_reg[15:8] + arg_reg[7:0];

    always_comb
    begin
        byte_next      = '0;
        frame_end_next = 1'b0;
        case (mode_reg)
            mcf_pkg::PROTO_LONG:
            begin
                frame_end_next = (long_pos == 4'd9);
                case (long_pos)
                    4'd0:    byte_next = mcf_pkg::LONG_START;
                    4'd1:    byte_next = mcf_pkg::LONG_VER;
                    4'd2:    byte_next = mcf_pkg::LONG_LEN;
                    4'd3:    byte_next = frame_cmd;
                    4'd4:    byte_next = mcf_pkg::LONG_PAD;
                    4'd5:    byte_next = frame_arg[15:8];
                    4'd6:    byte_next = frame_arg[7:0];
                    4'd7:    byte_next = long_chk[15:8];
                    4'd8:    byte_next = long_chk[7:0];
                    default: byte_next = mcf_pkg::LONG_END;
                endcase
            end
            mcf_pkg::PROTO_SHORT:
            begin
                if (track_part)
                begin
                    frame_end_next = (idx_reg == mcf_pkg::TRACK_FRAME - 5'd1);
                    case (idx_reg[2:0])
                        3'd0:    byte_next = mcf_pkg::SHORT_START;
                        3'd1:    byte_next = mcf_pkg::SHORT_TRACK_OP;
                        3'd2:    byte_next = mcf_pkg::SHORT_TRACK_LEN;
                        3'd3:    byte_next = arg_reg[15:8];
                        3'd4:    byte_next = arg_reg[7:0];
                        default: byte_next = track_sum;
                    endcase
                end
                else
                begin
                    frame_end_next = (short_pos == 3'd4);
                    case (short_pos)
                        3'd0:    byte_next = mcf_pkg::SHORT_START;
                        3'd1:    byte_next = sb1;
                        3'd2:    byte_next = sb2;
                        3'd3:    byte_next = sb3;
                        default: byte_next = short_sum;
                    endcase
                end
            end
            default:
                ;
        endcase
    end

    assign serial_bytes.valid     = out_valid_reg;
    assign serial_bytes.out_byte  = out_byte_reg;
    assign serial_bytes.frame_end = frame_end_reg;
    assign serial_bytes.last      = last_reg;

    `MCF_ASSERT_IMP(a_idx_in_range, clk, rst_n, busy_reg, idx_reg < len_reg)
    `MCF_ASSERT_IMP(a_len_legal, clk, rst_n, busy_reg,
        len_reg == mcf_pkg::LEN_SHORT || len_reg == mcf_pkg::LEN_LONG ||
        len_reg == mcf_pkg::LEN_TRACK || len_reg == mcf_pkg::LEN_LONG_PAIR)
    `MCF_ASSERT_IMP(a_take_only_at_end, clk, rst_n, accept && busy_reg, emit && final_byte)
    `MCF_ASSERT_IMP(a_last_ends_frame, clk, rst_n,
        serial_bytes.valid && serial_bytes.last, serial_bytes.frame_end)
    `MCF_ASSERT_NEXT(a_emit_shows, clk, rst_n, emit, out_valid_reg)

endmodule

`default_nettype wire
